FILE: sv/zone_list_to_bitmask_core_assert.svh
// Assertion macros shared by the RTL files.
`ifndef ZONE_LIST_TO_BITMASK_CORE_ASSERT_SVH
`define ZONE_LIST_TO_BITMASK_CORE_ASSERT_SVH

// Clocked check, masked while reset is held.
`define ZLB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define ZLB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/zlb_pkg.sv
`default_nettype none
package zlb_pkg;

    localparam int ZONE_COUNT_DEF  = 128;
    localparam int ENTRY_CAP_DEF   = 127;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int MASK_BITS = 128;
    localparam int HALF_BITS = 64;
    localparam int TOTAL_W   = 7;

    localparam logic [7:0] ALL_CLEAR_CODE = 8'hFE;
    localparam logic [7:0] VALUE_MAX      = 8'd255;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_NINE      = 8'h39;
    localparam logic [7:0] CHAR_HYPHEN    = 8'h2D;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_NUL       = 8'h00;
    localparam logic [3:0] RADIX          = 4'd10;

    typedef enum logic [1:0] {
        KIND_DIGIT,
        KIND_HYPHEN,
        KIND_SPACE,
        KIND_OTHER
    } t_kind;

    // One classified character as it travels from front to back.
    typedef struct packed {
        t_kind      kind;
        logic [3:0] digit;
        logic       is_fe;
        logic       last;
    } t_op;

endpackage
`default_nettype wire

FILE: sv/zlb_in_if.sv
`default_nettype none
interface zlb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface
`default_nettype wire

FILE: sv/zlb_out_if.sv
`default_nettype none
interface zlb_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] mask_low;
    logic [63:0] mask_high;
    logic [6:0]  entry_total;

    modport source (output valid, output mask_low, output mask_high, output entry_total,
                    input ready);
    modport sink   (input valid, input mask_low, input mask_high, input entry_total,
                    output ready);
endinterface
`default_nettype wire

FILE: sv/zlb_front.sv
`default_nettype none
// Character classifier: turns each accepted byte into a queue word.
module zlb_front (
    zlb_in_if.sink       i_in,
    input  wire logic    i_q_ready,
    output zlb_pkg::t_op o_push_op,
    output logic         o_push
);

    assign i_in.ready = i_q_ready;
    assign o_push     = i_in.valid && i_q_ready;

    always_comb begin
        o_push_op.digit = 4'(i_in.char_code - zlb_pkg::CHAR_ZERO);
        o_push_op.is_fe = (i_in.char_code == zlb_pkg::ALL_CLEAR_CODE);
        o_push_op.last  = i_in.last;
        unique case (i_in.char_code) inside
            [zlb_pkg::CHAR_ZERO : zlb_pkg::CHAR_NINE]: o_push_op.kind = zlb_pkg::KIND_DIGIT;
            zlb_pkg::CHAR_HYPHEN:                      o_push_op.kind = zlb_pkg::KIND_HYPHEN;
            zlb_pkg::CHAR_SPACE, zlb_pkg::CHAR_NUL:    o_push_op.kind = zlb_pkg::KIND_SPACE;
            default:                                   o_push_op.kind = zlb_pkg::KIND_OTHER;
        endcase
    end

endmodule
`default_nettype wire

FILE: sv/zlb_queue.sv
`default_nettype none
`include "zone_list_to_bitmask_core_assert.svh"
// Short queue between classifier and executor.
module zlb_queue #(
    parameter int DEPTH = zlb_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire zlb_pkg::t_op i_push_op,
    output logic              o_ready,
    output logic              o_valid,
    output zlb_pkg::t_op      o_op,
    input  wire logic         i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    zlb_pkg::t_op     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_ready = (r_count != FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_op;
        end
    end

    `ZLB_ASSERT(a_q_no_underflow, i_clk, i_rst_n, i_pop |-> (r_count != '0), "queue pop while empty")
    `ZLB_ASSERT(a_q_no_overflow, i_clk, i_rst_n, i_push |-> (r_count != FULL_CNT), "queue push while full")
    `ZLB_ASSERT_ALWAYS(a_q_bound, i_clk, !i_rst_n || (r_count <= FULL_CNT), "queue fill above depth")

endmodule
`default_nettype wire

FILE: sv/zlb_back.sv
`default_nettype none
`include "zone_list_to_bitmask_core_assert.svh"
// Executor: list state, range span and the result register.
module zlb_back #(
    parameter int ZONE_COUNT = zlb_pkg::ZONE_COUNT_DEF,
    parameter int ENTRY_CAP  = zlb_pkg::ENTRY_CAP_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_op_valid,
    input  wire zlb_pkg::t_op i_op,
    output logic              o_op_pop,
    zlb_out_if.source         o_out
);

    localparam int ZL    = (ZONE_COUNT < zlb_pkg::MASK_BITS) ? ZONE_COUNT : zlb_pkg::MASK_BITS;
    localparam int CNT_W = $clog2(ENTRY_CAP + 1);
    localparam logic [CNT_W-1:0] CAP = CNT_W'(ENTRY_CAP);

    logic [ZL-1:0]    r_mask;
    logic [CNT_W-1:0] r_count;
    logic [7:0]       r_pending;
    logic [7:0]       r_start;
    logic             r_in_range;
    logic             r_at_first;
    logic             r_all_clear;

    logic                           r_out_valid;
    logic [zlb_pkg::HALF_BITS-1:0]  r_out_low;
    logic [zlb_pkg::HALF_BITS-1:0]  r_out_high;
    logic [zlb_pkg::TOTAL_W-1:0]    r_out_total;

    logic [ZL-1:0]    n_mask;
    logic [CNT_W-1:0] n_count;
    logic [7:0]       n_pending;
    logic [7:0]       n_start;
    logic             n_in_range;
    logic             n_all_clear;

    logic go;
    logic fe_hit;
    logic active;

    assign go       = i_op_valid && (!i_op.last || !r_out_valid || o_out.ready);
    assign o_op_pop = go;
    assign fe_hit   = r_at_first && i_op.is_fe;
    assign active   = !r_all_clear && !fe_hit && (r_count < CAP);

    always_comb begin
        logic [11:0]      prod;
        logic [7:0]       pv_sat;
        logic [7:0]       pv_a;
        logic [CNT_W-1:0] cnt_a;
        logic [7:0]       start_a;
        logic             inr_a;
        logic             hy_en;
        logic             term;
        logic             cm_en;
        logic             rng_en;
        logic [8:0]       first;
        logic [8:0]       endv;
        logic [8:0]       len;
        logic [8:0]       room;
        logic [8:0]       n_add;
        logic [8:0]       z;
        logic [ZL-1:0]    marks;

        // decimal step, saturating
        prod   = 12'(r_pending) * 12'(zlb_pkg::RADIX) + 12'(i_op.digit);
        pv_sat = (prod > 12'(zlb_pkg::VALUE_MAX)) ? zlb_pkg::VALUE_MAX : prod[7:0];

        pv_a    = r_pending;
        cnt_a   = r_count;
        start_a = r_start;
        inr_a   = r_in_range;
        hy_en   = 1'b0;
        if (active) begin
            case (i_op.kind)
                zlb_pkg::KIND_DIGIT: pv_a = pv_sat;
                zlb_pkg::KIND_HYPHEN: begin
                    // commit range start as an entry; active implies room
                    hy_en   = 1'b1;
                    cnt_a   = r_count + 1'b1;
                    start_a = r_pending;
                    inr_a   = 1'b1;
                    pv_a    = '0;
                end
                default: ;
            endcase
        end

        term   = active && ((i_op.kind == zlb_pkg::KIND_SPACE) || i_op.last);
        cm_en  = term && !inr_a && (cnt_a < CAP);

        first  = 9'(start_a) + 9'd1;
        endv   = 9'(pv_a);
        rng_en = term && inr_a && (endv >= first);
        len    = endv - first + 9'd1;
        room   = 9'(CAP - cnt_a);
        n_add  = '0;
        if (rng_en) begin
            n_add = (len < room) ? len : room;
        end

        // per-zone marks: hyphen start, single commit, capped span
        for (int i = 0; i < ZL; i++) begin
            z = 9'(i + 1);
            marks[i] = (hy_en && (9'(r_pending) == z))
                    || (cm_en && (9'(pv_a) == z))
                    || (rng_en && (z >= first) && (z <= endv) && ((z - first) < room));
        end

        n_mask      = r_mask | marks;
        n_count     = cnt_a;
        if (cm_en) begin
            n_count = cnt_a + 1'b1;
        end else if (rng_en) begin
            n_count = cnt_a + CNT_W'(n_add);
        end
        n_pending   = term ? '0 : pv_a;
        n_start     = start_a;
        n_in_range  = term ? 1'b0 : inr_a;
        n_all_clear = r_all_clear || fe_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_count     <= '0;
            r_pending   <= '0;
            r_start     <= '0;
            r_in_range  <= 1'b0;
            r_at_first  <= 1'b1;
            r_all_clear <= 1'b0;
        end else if (go) begin
            if (i_op.last) begin
                r_mask      <= '0;
                r_count     <= '0;
                r_pending   <= '0;
                r_start     <= '0;
                r_in_range  <= 1'b0;
                r_at_first  <= 1'b1;
                r_all_clear <= 1'b0;
            end else begin
                r_mask      <= n_mask;
                r_count     <= n_count;
                r_pending   <= n_pending;
                r_start     <= n_start;
                r_in_range  <= n_in_range;
                r_at_first  <= 1'b0;
                r_all_clear <= n_all_clear;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go && i_op.last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [zlb_pkg::MASK_BITS-1:0] full;
        logic [8:0]                    cnt9;
        full = n_all_clear ? '0 : zlb_pkg::MASK_BITS'(n_mask);
        cnt9 = n_all_clear ? '0 : 9'(n_count);
        if (go && i_op.last) begin
            r_out_low   <= full[zlb_pkg::HALF_BITS-1:0];
            r_out_high  <= full[zlb_pkg::MASK_BITS-1:zlb_pkg::HALF_BITS];
            r_out_total <= cnt9[zlb_pkg::TOTAL_W-1:0];
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.mask_low    = r_out_low;
    assign o_out.mask_high   = r_out_high;
    assign o_out.entry_total = r_out_total;

    `ZLB_ASSERT_ALWAYS(a_cnt_cap, i_clk, !i_rst_n || (r_count <= CAP), "entry count above cap")
    `ZLB_ASSERT(a_last_resets, i_clk, i_rst_n, (go && i_op.last) |=> ((r_count == '0) && r_at_first && !r_all_clear && !r_in_range && (r_mask == '0)), "list state not cleared after last word")
    `ZLB_ASSERT(a_all_clear_zero, i_clk, i_rst_n, (go && i_op.last && n_all_clear) |=> ((o_out.entry_total == '0) && (o_out.mask_low == '0) && (o_out.mask_high == '0)), "all-clear result not zero")

endmodule
`default_nettype wire

FILE: sv/zone_list_to_bitmask_core.sv
// Output: o_out.valid is registered and set at the edge where the executor pops the word
//   carrying last; that pop waits while an earlier result word still waits on o_out.ready.
// Throughput: one character word per cycle unless a last word waits on o_out.ready;
//   set by the executor's update: decimal step plus capped range span over every zone bit.
// Reset: i_rst_n synchronous, active low; clears the queue, the list state
//   (at_first_byte set) and the result valid flag. No clearing pass.
`default_nettype none
module zone_list_to_bitmask_core #(
    parameter int ZONE_COUNT  = zlb_pkg::ZONE_COUNT_DEF,
    parameter int ENTRY_CAP   = zlb_pkg::ENTRY_CAP_DEF,
    parameter int QUEUE_DEPTH = zlb_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    zlb_in_if.sink    i_in,
    zlb_out_if.source o_out
);

    // Front side: classify the byte and push it as a queue word.
    // Queue ready depends only on its own fill, so i_in.ready waits on the
    // output side only when the queue fills behind a stalled last word.
    zlb_pkg::t_op push_op;
    logic         push;
    logic         q_ready;

    // Back side: pop and execute one word a cycle; only a last word
    // waits for the result register to be free.
    zlb_pkg::t_op pop_op;
    logic         pop_valid;
    logic         pop;

    zlb_front u_front (
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_push_op (push_op),
        .o_push    (push)
    );

    zlb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_push_op (push_op),
        .o_ready   (q_ready),
        .o_valid   (pop_valid),
        .o_op      (pop_op),
        .i_pop     (pop)
    );

    // Executor holds zone mask, entry count, pending value, range start
    // and the first-byte / all-clear flags; the result register parts it
    // from the output handshake.
    zlb_back #(
        .ZONE_COUNT (ZONE_COUNT),
        .ENTRY_CAP  (ENTRY_CAP)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (pop_valid),
        .i_op       (pop_op),
        .o_op_pop   (pop),
        .o_out      (o_out)
    );

endmodule
`default_nettype wire
